// ----- sv/rlcf_pkg.sv -----
// Shared types, constants and controller codes for the RGB linear colour fade.
package rlcf_pkg;

  // Field widths of the request and result items
  localparam int COLOUR_W = 8;
  localparam int STEP_W   = 7;

  // Defaults for the top-level parameters
  localparam int MAX_STEPS_DEF   = 64;
  localparam int COLOUR_BITS_DEF = 8;

  // One fade request
  typedef struct packed {
    logic [COLOUR_W-1:0] start_red;
    logic [COLOUR_W-1:0] start_green;
    logic [COLOUR_W-1:0] start_blue;
    logic [COLOUR_W-1:0] target_red;
    logic [COLOUR_W-1:0] target_green;
    logic [COLOUR_W-1:0] target_blue;
    logic [STEP_W-1:0]   step_total;
  } fade_req_t;

  // One step result
  typedef struct packed {
    logic [COLOUR_W-1:0] red_level;
    logic [COLOUR_W-1:0] green_level;
    logic [COLOUR_W-1:0] blue_level;
    logic                last_step;
  } fade_res_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } fade_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic req_zero;
    logic div_done;
    logic at_last;
    logic out_room;
  } fade_sts_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } fade_state_t;

endpackage

// ----- sv/rgb_linear_colour_fade.sv -----
// Top level of the RGB linear colour fade generator.
//
// Usage: a fade request (start and target red, green, blue and a step count n)
// enters on the in_ channel; the block answers with n step results on the out_
// channel, each giving the three inverted compare levels, the last one marked
// by last_step. A step count of zero yields no result; counts above MAX_STEPS
// are clipped to MAX_STEPS.
// Sequence: the request is taken, then the three per-channel step sizes are
// found by bit-serial dividers over min(COLOUR_BITS, 8) quotient bits, then
// one result is produced per cycle into the output register while the
// receiver does not stall.
// in_stall stays high from the cycle after acceptance until the last result has
// been loaded; a new request may be taken while that last result still waits.
// A stalled receiver holds the current result and pauses the step sequence.
// Reset (rst_n low, synchronous) returns the block to idle and empties the
// output register.
module rgb_linear_colour_fade #(
  parameter int MAX_STEPS   = rlcf_pkg::MAX_STEPS_DEF,
  parameter int COLOUR_BITS = rlcf_pkg::COLOUR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rlcf_pkg::fade_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rlcf_pkg::fade_res_t out_data
);
  import rlcf_pkg::*;

  fade_cmd_t cmd;
  fade_sts_t sts;

  // Sequence the request
  rlcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Divide, accumulate and hold results
  rlcf_datapath #(
    .MAX_STEPS   (MAX_STEPS),
    .COLOUR_BITS (COLOUR_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // At most one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.emit}))
    else $error("controller issued overlapping commands");

  // Never overwrite a result that has not been taken
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.emit)
    else $error("result overwritten while stalled");

  // A non-empty request starts division next cycle
  a_load_divide: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !sts.req_zero) |=> (cmd.div_step && in_stall))
    else $error("division did not follow request");

  // The final step ends the emission
  a_last_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.at_last) |=> !cmd.emit)
    else $error("emission continued past the last step");

endmodule

// ----- sv/rlcf_ctrl.sv -----
// Controller state machine: request intake, division sequencing and step emission.
module rlcf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rlcf_pkg::fade_sts_t sts,
  output rlcf_pkg::fade_cmd_t cmd
);
  import rlcf_pkg::*;

  fade_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          // a request with no steps produces nothing
          if (!sts.req_zero) state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_room) begin
          cmd.emit = 1'b1;
          if (sts.at_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/rlcf_datapath.sv -----
// Datapath: per-channel step dividers, offset accumulators and result register.
module rlcf_datapath #(
  parameter int MAX_STEPS   = rlcf_pkg::MAX_STEPS_DEF,
  parameter int COLOUR_BITS = rlcf_pkg::COLOUR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rlcf_pkg::fade_req_t in_data,
  input  rlcf_pkg::fade_cmd_t cmd,
  output rlcf_pkg::fade_sts_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output rlcf_pkg::fade_res_t out_data
);
  import rlcf_pkg::*;

  // Colour value width inside the block, step count width, division bit count width
  localparam int VW = (COLOUR_BITS < COLOUR_W) ? COLOUR_BITS : COLOUR_W;
  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int BW = $clog2(VW);

  logic [VW-1:0] start_r  [3];
  logic          down_r   [3];
  logic [VW-1:0] quo_r    [3];   // dividend on load, step size once divided
  logic [NW-1:0] rem_r    [3];
  logic [VW-1:0] offset_r [3];
  logic [NW-1:0] n_r;
  logic [NW-1:0] k_r;
  logic [BW-1:0] bitcnt_r;
  logic          out_valid_r;
  fade_res_t     out_data_r;

  logic [VW-1:0] start_in  [3];
  logic [VW-1:0] target_in [3];
  logic [VW-1:0] dist_in   [3];
  logic          down_in   [3];
  logic [NW-1:0] n_in;
  logic [NW:0]   trial     [3];
  logic          ge        [3];
  logic [NW-1:0] rem_nxt   [3];
  logic [VW-1:0] quo_nxt   [3];
  logic [VW-1:0] offset_nxt[3];
  logic [VW-1:0] level     [3];
  logic [VW-1:0] inv       [3];

  // Take channel values in their low colour bits and form distances
  always_comb begin
    start_in[0]  = in_data.start_red[VW-1:0];
    start_in[1]  = in_data.start_green[VW-1:0];
    start_in[2]  = in_data.start_blue[VW-1:0];
    target_in[0] = in_data.target_red[VW-1:0];
    target_in[1] = in_data.target_green[VW-1:0];
    target_in[2] = in_data.target_blue[VW-1:0];
    for (int l = 0; l < 3; l++) begin
      down_in[l] = start_in[l] > target_in[l];
      dist_in[l] = down_in[l] ? (start_in[l] - target_in[l])
                              : (target_in[l] - start_in[l]);
    end
  end

  // Saturate the step count
  always_comb begin
    if (in_data.step_total > STEP_W'(MAX_STEPS)) begin
      n_in = NW'(MAX_STEPS);
    end else begin
      n_in = NW'(in_data.step_total);
    end
  end

  // One restoring division bit per lane per cycle
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      trial[l]   = {rem_r[l], quo_r[l][VW-1]};
      ge[l]      = trial[l] >= {1'b0, n_r};
      rem_nxt[l] = ge[l] ? NW'(trial[l] - {1'b0, n_r}) : NW'(trial[l]);
      quo_nxt[l] = {quo_r[l][VW-2:0], ge[l]};
    end
  end

  // Advance offsets and invert the levels for an active-low compare
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      offset_nxt[l] = offset_r[l] + quo_r[l];
      level[l]      = down_r[l] ? (start_r[l] - offset_nxt[l])
                                : (start_r[l] + offset_nxt[l]);
      inv[l]        = ~level[l];
    end
  end

  // Lane registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int l = 0; l < 3; l++) begin
        start_r[l]  <= start_in[l];
        down_r[l]   <= down_in[l];
        quo_r[l]    <= dist_in[l];
        rem_r[l]    <= '0;
        offset_r[l] <= '0;
      end
      n_r      <= n_in;
      bitcnt_r <= '0;
    end else if (cmd.div_step) begin
      for (int l = 0; l < 3; l++) begin
        quo_r[l] <= quo_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
      bitcnt_r <= bitcnt_r + 1'b1;
    end else if (cmd.emit) begin
      for (int l = 0; l < 3; l++) begin
        offset_r[l] <= offset_nxt[l];
      end
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.load) begin
      k_r <= '0;
    end else if (cmd.emit) begin
      k_r <= k_r + 1'b1;
    end
  end

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.red_level   <= COLOUR_W'(inv[0]);
      out_data_r.green_level <= COLOUR_W'(inv[1]);
      out_data_r.blue_level  <= COLOUR_W'(inv[2]);
      out_data_r.last_step   <= sts.at_last;
    end
  end

  // Status to the controller
  always_comb begin
    sts.req_zero = in_data.step_total == '0;
    sts.div_done = bitcnt_r == BW'(VW - 1);
    sts.at_last  = ({1'b0, k_r} + 1'b1) == {1'b0, n_r};
    sts.out_room = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
